// File: rtl/core/sspd_pkg.sv
`default_nettype none
package sspd_pkg;

  // Reset values of the configuration registers
  localparam logic [15:0] FRAC_DEFAULT_RST = 16'd32768;
  localparam logic [15:0] SOF_CENTER_RST   = 16'd22000;
  localparam logic [11:0] VERIFY_TIME_RST  = 12'd3000;
  localparam logic [7:0]  RESET_TIME_RST   = 8'd200;

  // Clamp window around the nominal value
  localparam logic [15:0] CLAMP_BELOW = 16'd1000;
  localparam logic [15:0] CLAMP_ABOVE = 16'd500;
  localparam logic [15:0] FRAC_MAX    = 16'hFFFF;

  // P gain 1/2500 as reciprocal multiply: ceil(2^26 / 2500)
  localparam logic [14:0] P_RECIP = 15'd26844;
  localparam int          P_SHIFT = 26;

  // Jitter thresholds
  localparam logic [14:0] JIT_LOW   = 15'd2;
  localparam logic [14:0] JIT_HIGH  = 15'd7;
  localparam logic [5:0]  JIT_LIMIT = 6'd50;

  // Aux clock divider codes
  localparam logic [3:0] DIV_NOM  = 4'd13;
  localparam logic [3:0] DIV_HIGH = 4'd14;

  typedef enum logic [1:0] {
    REG_FRAC_DEFAULT = 2'd0,
    REG_SOF_CENTER   = 2'd1,
    REG_VERIFY_TIME  = 2'd2,
    REG_RESET_TIME   = 2'd3
  } sspd_reg_t;

  typedef struct packed {
    logic [15:0] frac_default;
    logic [15:0] sof_center;
    logic [11:0] verify_time;
    logic [7:0]  reset_time;
  } sspd_cfg_t;

  // Front stage result: frame error and its P term
  typedef struct packed {
    logic signed [15:0] err;
    logic signed [4:0]  pterm;
  } sspd_pd_t;

endpackage
`default_nettype wire

// File: rtl/core/sof_sync_pd_loop_with_pll_check.sv
// A result beat passes two registers after its input beat is accepted
//   (front register holding error and P term, then the loop/result register).
// Throughput: 1 beat per cycle unless out_ready stalls the result channel.
// Beats with frame_position bit 0 clear are accepted and give no result.
// Reset (rst_n low, synchronous) restores register defaults and loop state.
`default_nettype none
module sof_sync_pd_loop_with_pll_check
  import sspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel: one measured frame position per beat
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] in_frame_position,
  // result channel
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_frac_value,
  output      logic        out_led_on,
  output      logic [3:0]  out_clock_divider,
  // APB-style register port, registers at byte offsets 0, 4, 8, 12
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  sspd_cfg_t cfg;
  logic      pd_valid;
  sspd_pd_t  pd;
  logic      take;

  // Register file: nominal value, target position, verify and hold times.
  sspd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // Front stage: error from center and the P term, which do not depend
  // on loop state, are computed and registered as the beat enters.
  sspd_err u_err (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_frame_position (in_frame_position),
    .sof_center        (cfg.sof_center),
    .take              (take),
    .pd_valid          (pd_valid),
    .pd                (pd)
  );

  // Loop stage: D term, wrap and clamp, jitter check and PLL reset
  // sequencing; its state registers drive the result beat directly.
  sspd_loop u_loop (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .pd_valid          (pd_valid),
    .pd                (pd),
    .take              (take),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frac_value    (out_frac_value),
    .out_led_on        (out_led_on),
    .out_clock_divider (out_clock_divider)
  );

endmodule
`default_nettype wire

// File: rtl/core/sspd_cfg.sv
`default_nettype none
module sspd_cfg
  import sspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready,
  output      sspd_cfg_t   cfg
);

  sspd_cfg_t cfg_r;
  logic      wr_en;
  sspd_reg_t idx;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = sspd_reg_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frac_default <= FRAC_DEFAULT_RST;
      cfg_r.sof_center   <= SOF_CENTER_RST;
      cfg_r.verify_time  <= VERIFY_TIME_RST;
      cfg_r.reset_time   <= RESET_TIME_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_FRAC_DEFAULT: cfg_r.frac_default <= cfg_pwdata[15:0];
        REG_SOF_CENTER:   cfg_r.sof_center   <= cfg_pwdata[15:0];
        REG_VERIFY_TIME:  cfg_r.verify_time  <= cfg_pwdata[11:0];
        REG_RESET_TIME:   cfg_r.reset_time   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAC_DEFAULT: cfg_prdata = {16'd0, cfg_r.frac_default};
      REG_SOF_CENTER:   cfg_prdata = {16'd0, cfg_r.sof_center};
      REG_VERIFY_TIME:  cfg_prdata = {20'd0, cfg_r.verify_time};
      REG_RESET_TIME:   cfg_prdata = {24'd0, cfg_r.reset_time};
      default:          cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/sspd_err.sv
`default_nettype none
module sspd_err
  import sspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] in_frame_position,
  input  wire logic [15:0] sof_center,
  input  wire logic        take,
  output      logic        pd_valid,
  output      sspd_pd_t    pd
);

  logic               valid_r;
  sspd_pd_t           pd_r;
  logic signed [15:0] err;
  logic [15:0]        mag;
  logic [30:0]        prod;
  logic [4:0]         quo;
  logic signed [4:0]  pterm;
  logic               acc;

  assign in_ready = !valid_r || take;
  assign acc      = in_valid && in_ready;

  // error wraps to 16 bits; |err| / 2500 by reciprocal multiply, max 13
  assign err   = signed'(in_frame_position - sof_center);
  assign mag   = err[15] ? 16'(-err) : 16'(err);
  assign prod  = 31'(mag) * 31'(P_RECIP);
  assign quo   = prod[P_SHIFT+4:P_SHIFT];
  assign pterm = err[15] ? -signed'(quo) : signed'(quo);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (acc) begin
      valid_r <= in_frame_position[0];  // beats without the flag drop here
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pd_r.err   <= err;
      pd_r.pterm <= pterm;
    end
  end

  assign pd_valid = valid_r;
  assign pd       = pd_r;

endmodule
`default_nettype wire

// File: rtl/core/sspd_loop.sv
`default_nettype none
module sspd_loop
  import sspd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire sspd_cfg_t   cfg,
  input  wire logic        pd_valid,
  input  wire sspd_pd_t    pd,
  output      logic        take,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_frac_value,
  output      logic        out_led_on,
  output      logic [3:0]  out_clock_divider
);

  logic               out_valid_r;
  logic [15:0]        frac_r, frac_nxt;
  logic signed [15:0] prev_r;
  logic [7:0]         rc_r, rc_nxt;
  logic [11:0]        vc_r, vc_nxt;
  logic [14:0]        avg_r, avg_nxt;
  logic [5:0]         ev_r, ev_nxt;
  logic               led_r, led_nxt;
  logic               div_r, div_nxt;

  logic signed [15:0] diff;
  logic signed [15:0] diff_adj;
  logic signed [15:0] dterm;
  logic [15:0]        step;
  logic [15:0]        lo, hi, clamped;
  logic [15:0]        dmag;
  logic [16:0]        avg_sum;
  logic [14:0]        avg_new;
  logic [5:0]         ev_new;

  assign take = pd_valid && (!out_valid_r || out_ready);

  // PD step: D term truncates toward zero
  assign diff     = pd.err - prev_r;
  assign diff_adj = diff + signed'({15'd0, diff[15]});
  assign dterm    = diff_adj >>> 1;
  assign step     = frac_r + {{11{pd.pterm[4]}}, pd.pterm} + dterm;

  assign lo = (cfg.frac_default < CLAMP_BELOW) ? 16'd0
                                               : cfg.frac_default - CLAMP_BELOW;
  assign hi = (cfg.frac_default > FRAC_MAX - CLAMP_ABOVE) ? FRAC_MAX
                                                          : cfg.frac_default + CLAMP_ABOVE;

  always_comb begin
    clamped = (step > hi) ? hi : step;
    if (clamped < lo) begin
      clamped = lo;
    end
  end

  // jitter average: (avg + |diff|) mod 2^16, halved
  assign dmag    = diff[15] ? 16'(-diff) : 16'(diff);
  assign avg_sum = 17'(avg_r) + 17'(dmag);
  assign avg_new = avg_sum[15:1];

  always_comb begin
    ev_new = ev_r;
    if (avg_new < JIT_LOW) begin
      if (ev_r != 6'd0) begin
        ev_new = ev_r - 6'd1;
      end
    end else if (avg_new > JIT_HIGH) begin
      ev_new = ev_r + 6'd1;
    end
  end

  always_comb begin
    frac_nxt = clamped;
    rc_nxt   = rc_r;
    vc_nxt   = vc_r;
    avg_nxt  = avg_r;
    ev_nxt   = ev_r;
    led_nxt  = led_r;
    div_nxt  = div_r;
    if (vc_r != 12'd0) begin
      if (rc_r != 8'd0) begin
        // PLL hold phase
        frac_nxt = 16'd0;
        rc_nxt   = rc_r - 8'd1;
        if (rc_r == 8'd1) begin
          frac_nxt = cfg.frac_default;
          led_nxt  = 1'b0;
          div_nxt  = 1'b0;
        end
      end else begin
        vc_nxt  = vc_r - 12'd1;
        avg_nxt = avg_new;
        ev_nxt  = ev_new;
        if (ev_new > JIT_LIMIT) begin
          avg_nxt = 15'd0;
          ev_nxt  = 6'd0;
          rc_nxt  = cfg.reset_time;
          vc_nxt  = cfg.verify_time;
          led_nxt = 1'b1;
          div_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frac_r      <= FRAC_DEFAULT_RST;
      prev_r      <= 16'sd0;
      rc_r        <= 8'd0;
      vc_r        <= VERIFY_TIME_RST;
      avg_r       <= 15'd0;
      ev_r        <= 6'd0;
      led_r       <= 1'b0;
      div_r       <= 1'b0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        frac_r      <= frac_nxt;
        prev_r      <= pd.err;
        rc_r        <= rc_nxt;
        vc_r        <= vc_nxt;
        avg_r       <= avg_nxt;
        ev_r        <= ev_nxt;
        led_r       <= led_nxt;
        div_r       <= div_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // loop state doubles as the result register
  assign out_valid         = out_valid_r;
  assign out_frac_value    = frac_r;
  assign out_led_on        = led_r;
  assign out_clock_divider = div_r ? DIV_HIGH : DIV_NOM;

`ifndef SYNTHESIS
  a_led_div: assert property (@(posedge clk) disable iff (!rst_n)
    led_r == div_r)
    else $error("LED and divider state disagree");

  a_ev_max: assert property (@(posedge clk) disable iff (!rst_n)
    ev_r <= JIT_LIMIT)
    else $error("jitter count above reset limit");

  a_window_closed: assert property (@(posedge clk) disable iff (!rst_n)
    take && (vc_r == 12'd0) |=> (vc_r == 12'd0))
    else $error("verify window reopened without reset");

  a_hold_zero: assert property (@(posedge clk) disable iff (!rst_n)
    take && (vc_r != 12'd0) && (rc_r > 8'd1) |=> (frac_r == 16'd0))
    else $error("nonzero output during PLL hold");
`endif

endmodule
`default_nettype wire

// File: bench/tb_sof_sync_pd_loop_with_pll_check.sv
`default_nettype none
module tb_sof_sync_pd_loop_with_pll_check;
  import sspd_pkg::*;

  // Hard stop, well beyond the slowest legal run (~1.8k beats, worst gaps)
  localparam int RUN_LIMIT = 1_600_000;
  // Cycles to let the two-stage pipe empty after the last result beat
  localparam int PIPE_FLUSH = 4;
  // Cap on printed mismatch lines
  localparam int MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_frame_position = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_frac_value;
  logic        out_led_on;
  logic [3:0]  out_clock_divider;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sof_sync_pd_loop_with_pll_check dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_frame_position(in_frame_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frac_value   (out_frac_value),
    .out_led_on       (out_led_on),
    .out_clock_divider(out_clock_divider),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #4 clk = ~clk;

  // One expected result beat: trim value, LED and aux divider
  typedef struct packed {
    logic [15:0] frac;
    logic        led;
    logic [3:0]  div;
  } trim_t;

  logic [15:0] pos_q[$];       // frame positions waiting to be driven
  trim_t       trim_exp_q[$];  // predicted result beats, oldest first

  // Shadow copy of the register file, updated as each write lands
  logic [15:0] cur_frac_default = FRAC_DEFAULT_RST;
  logic [15:0] cur_sof_center   = SOF_CENTER_RST;
  logic [11:0] cur_verify_time  = VERIFY_TIME_RST;
  logic [7:0]  cur_reset_time   = RESET_TIME_RST;

  // Loop state of the predictor, at its reset values
  logic [15:0]        trim_reg  = FRAC_DEFAULT_RST;
  logic signed [15:0] prev_err  = '0;
  logic [7:0]         hold_left = '0;   // frames left in the hold of a PLL reset
  logic [11:0]        win_left  = VERIFY_TIME_RST; // verify window frames left
  logic [15:0]        jit_avg   = '0;
  logic [5:0]         jit_evt   = '0;
  logic               led_lit   = 1'b0;
  logic               div_hi    = 1'b0;

  logic steady = 1'b0;  // no idling on either side while set
  int   gap_left = 0;
  int   stall_left = 0;
  int   n_frames = 0;
  int   n_results = 0;
  int   n_resets = 0;
  int   n_fail = 0;

  // Advance the loop by one accepted frame; queue a result if it is valid.
  function automatic void predict_trim(input logic [15:0] pos);
    logic signed [15:0] err;
    logic signed [15:0] dif;
    logic [15:0]        sum16;
    int                 p_term, d_term, mag, lo, hi, nxt;
    trim_t              res;
    if (!pos[0]) return;  // no valid flag: dropped, state untouched
    err = pos - cur_sof_center;
    dif = err - prev_err;
    p_term = int'(err) / 2500;  // SV division truncates toward zero
    d_term = int'(dif) / 2;
    prev_err = err;
    nxt = (int'(trim_reg) + p_term + d_term) & 32'hFFFF;  // wraps at 16 bits
    // clamp window, each bound saturated to the 16-bit range
    lo = int'(cur_frac_default) - 1000;
    hi = int'(cur_frac_default) + 500;
    if (lo < 0) lo = 0;
    if (hi > 65535) hi = 65535;
    if (nxt > hi) nxt = hi;
    if (nxt < lo) nxt = lo;
    trim_reg = nxt[15:0];
    // PLL check runs only while the verify window is open
    if (win_left != 0) begin
      if (hold_left != 0) begin
        trim_reg = '0;
        hold_left--;
        if (hold_left == 0) begin
          led_lit = 1'b0;
          div_hi = 1'b0;
          trim_reg = cur_frac_default;
        end
      end else begin
        win_left--;
        mag = (dif < 0) ? -int'(dif) : int'(dif);
        sum16 = 16'(int'(jit_avg) + mag);
        jit_avg = sum16 >> 1;
        if (jit_avg < 2) begin
          if (jit_evt != 0) jit_evt--;
        end else if (jit_avg > 7) begin
          jit_evt++;
        end
        if (jit_evt > 50) begin
          // too much jitter: start a PLL reset; this frame keeps its value
          jit_avg = '0;
          jit_evt = '0;
          hold_left = cur_reset_time;
          win_left = cur_verify_time;
          led_lit = 1'b1;
          div_hi = 1'b1;
          n_resets++;
        end
      end
    end
    res.frac = trim_reg;
    res.led = led_lit;
    res.div = div_hi ? DIV_HIGH : DIV_NOM;
    trim_exp_q.push_back(res);
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  // Input driver: one beat per queued position, random gap after each beat unless steady is set.
  // The prediction is made at the edge where the beat is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_trim(in_frame_position);
        n_frames++;
      end
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pos_q.size() != 0) begin
        in_valid <= 1'b1;
        in_frame_position <= pos_q.pop_front();
        gap_left <= steady ? 0 : $urandom_range(0, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks every accepted beat, then may stall out_ready at random unless steady is set
  always @(posedge clk) begin : result_check
    int    w;
    trim_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (trim_exp_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected, got frac %0d led %0d div %0d",
                     $time, out_frac_value, out_led_on, out_clock_divider);
        end else begin
          want = trim_exp_q.pop_front();
          if (out_frac_value !== want.frac)
            report_mismatch("frac_value", int'(want.frac), int'(out_frac_value));
          if (out_led_on !== want.led)
            report_mismatch("led_on", int'(want.led), int'(out_led_on));
          if (out_clock_divider !== want.div)
            report_mismatch("clock_divider", int'(want.div), int'(out_clock_divider));
        end
        w = steady ? 0 : $urandom_range(0, 3);
        stall_left <= w;
        out_ready <= (w == 0);
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // APB write with setup and access phase, then read the register back
  task automatic write_reg(input sspd_reg_t r, input logic [31:0] v);
    logic [31:0] mask;
    case (r)
      REG_FRAC_DEFAULT, REG_SOF_CENTER: mask = 32'hFFFF;
      REG_VERIFY_TIME: mask = 32'hFFF;
      default: mask = 32'hFF;
    endcase
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (r)
      REG_FRAC_DEFAULT: cur_frac_default = v[15:0];
      REG_SOF_CENTER: cur_sof_center = v[15:0];
      REG_VERIFY_TIME: cur_verify_time = v[11:0];
      default: cur_reset_time = v[7:0];
    endcase
    // read-back: setup starts at the edge the write completed
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== (v & mask))
      report_mismatch("register read-back", v & mask, cfg_prdata);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_loop(input logic [15:0] frac, input logic [15:0] center,
                          input logic [11:0] verify, input logic [7:0] hold);
    write_reg(REG_FRAC_DEFAULT, 32'(frac));
    write_reg(REG_SOF_CENTER, 32'(center));
    write_reg(REG_VERIFY_TIME, 32'(verify));
    write_reg(REG_RESET_TIME, 32'(hold));
  endtask

  // Wait until every beat is out and checked, then let the pipe empty
  task automatic drain();
    while (pos_q.size() != 0 || in_valid || trim_exp_q.size() != 0) @(posedge clk);
    repeat (PIPE_FLUSH) @(posedge clk);
  endtask

  // Queue random traffic until n_valid flagged frames are in. Mostly
  // well-formed runs around the target (calm tracking, jitter bursts long
  // enough to trip a PLL reset, ramps), plus raw noise and dropped frames.
  task automatic feed_frames(input int n_valid, input logic no_idle);
    logic [15:0] pos;
    int          made, kind, len, base, off, i;
    made = 0;
    @(negedge clk);
    steady = no_idle;
    while (made < n_valid) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) len = $urandom_range(10, 40);
      else if (kind <= 6) len = $urandom_range(55, 80);
      else if (kind == 7) len = $urandom_range(10, 30);
      else len = $urandom_range(1, 8);
      base = int'($urandom_range(0, 6000)) - 3000;
      for (i = 0; i < len; i++) begin
        if (kind <= 3) off = base + 2 * int'($urandom_range(0, 2)) - 2;
        else if (kind <= 6) off = int'($urandom_range(0, 16000)) - 8000;
        else off = base + i * 64;
        if (kind >= 8) begin
          pos = 16'($urandom_range(0, 65535));
        end else begin
          pos = 16'(int'(cur_sof_center) + off) | 16'd1;
          if ($urandom_range(0, 9) == 0) pos[0] = 1'b0;  // dropped frame
        end
        if (pos[0]) made++;
        pos_q.push_back(pos);
      end
    end
  endtask

  // Directed frames at reset settings: field extremes, P-term boundaries
  // around +/-2500, error wrap, clamp at both ends, a calm run
  logic [15:0] edge_frames [22] = '{
    16'h0000, 16'hFFFE, 16'hFFFF, 16'h0001, 16'd22001, 16'd22001,
    16'd24499, 16'd24501, 16'd19501, 16'd19499, 16'h7FFF, 16'h8001,
    16'd54767, 16'h5555, 16'hAAAB, 16'hAAAA, 16'd22001, 16'd22001,
    16'd22001, 16'd22003, 16'd21999, 16'd22001
  };

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (edge_frames[i]) pos_q.push_back(edge_frames[i]);
    drain();

    // low nominal, target 0, longest window, one-frame hold
    set_loop(16'd1000, 16'd0, 12'd4095, 8'd1);
    feed_frames(250, 1'b0);
    drain();
    // high nominal, top target, longest hold, back-to-back beats
    set_loop(16'd65035, 16'd65535, 12'd2500, 8'd255);
    feed_frames(250, 1'b1);
    drain();
    // clamp max saturates; zero hold time leaves LED and divider set
    set_loop(16'd65535, 16'($urandom_range(0, 65535)), 12'd1500, 8'd0);
    feed_frames(200, 1'b0);
    drain();
    // clamp min saturates at 0; a short hold lets a later reset clear LED and divider
    set_loop(16'd200, 16'd22000, 12'd800, 8'd5);
    feed_frames(200, 1'b1);
    drain();
    // random settings, odd target
    set_loop(16'($urandom_range(1000, 65035)), 16'($urandom_range(0, 65535)) | 16'd1,
             12'($urandom_range(200, 4095)), 8'($urandom_range(1, 30)));
    feed_frames(250, 1'b0);
    drain();
    // zero verify time: next reset closes the window, hold never runs
    set_loop(16'($urandom_range(1000, 65035)), 16'($urandom_range(0, 65535)),
             12'd0, 8'd10);
    feed_frames(150, 1'b0);
    drain();

    $display("covered %0d frame beats, %0d result beats checked, %0d PLL resets,",
             n_frames, n_results, n_resets);
    $display("  over 7 register settings with idle and back-to-back traffic");
    if (n_fail == 0) begin
      $display("tb_sof_sync_pd_loop_with_pll_check passed");
    end else begin
      $display("tb_sof_sync_pd_loop_with_pll_check failed");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("timeout with %0d beats pending", pos_q.size() + trim_exp_q.size());
    $display("tb_sof_sync_pd_loop_with_pll_check failed");
    $finish;
  end

endmodule
`default_nettype wire
